/* rtl/tccw_pkg.sv */
// Shared constants, types and helpers for the text console character writer.
`timescale 1ns / 1ps

package tccw_pkg;

    localparam int COLUMNS_DEFAULT = 80;
    localparam int ROWS_DEFAULT    = 25;

    localparam int MODE_W       = 2;
    localparam int CHAR_W       = 8;
    localparam int COLOR_W      = 4;
    localparam int COLUMN_W     = 7;
    localparam int LINE_W       = 5;
    localparam int CURSOR_LOC_W = 11;
    localparam int CELL_W       = 16;
    localparam int CFG_INDEX_W  = 1;

    localparam logic [MODE_W-1:0] MODE_WRITE_CHAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SET_CURSOR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR      = 2'd2;
    localparam logic [MODE_W-1:0] MODE_READ_CELL  = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_DEFAULT_BACK = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEFAULT_FORE = 1'd1;

    localparam logic [CHAR_W-1:0] CH_BACKSPACE  = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB        = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF         = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR         = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE      = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PRINT_LAST = 8'h7F;

    localparam logic [CELL_W-1:0]  BLANK_CELL         = 16'h0F20;
    localparam logic [COLOR_W-1:0] DEFAULT_BACK_RESET = 4'd0;
    localparam logic [COLOR_W-1:0] DEFAULT_FORE_RESET = 4'd15;

    localparam logic [1:0] SWEEP_INIT   = 2'd0;
    localparam logic [1:0] SWEEP_CLEAR  = 2'd1;
    localparam logic [1:0] SWEEP_SCROLL = 2'd2;

    typedef struct packed {
        logic       accept;
        logic       sweep_run;
        logic [1:0] sweep_kind;
        logic       finish;
    } tccw_cmd_t;

    typedef struct packed {
        logic clear_req;
        logic scroll_req;
        logic sweep_done;
        logic out_free;
    } tccw_status_t;

    function automatic logic [CELL_W-1:0] make_cell(
        input logic [COLOR_W-1:0] back,
        input logic [COLOR_W-1:0] fore,
        input logic [CHAR_W-1:0]  ch
    );
        return {back, fore, ch};
    endfunction

endpackage

/* rtl/tccw_ctrl.sv */
// Controller state machine: item acceptance, screen sweeps and result hand-off.
`timescale 1ns / 1ps

module tccw_ctrl
    import tccw_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  tccw_status_t status,
    output tccw_cmd_t    cmd
);

    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SCROLL = 3'd2;
    localparam logic [2:0] ST_CLEAR  = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd.accept     = 1'b0;
        cmd.sweep_run  = 1'b0;
        cmd.sweep_kind = SWEEP_INIT;
        cmd.finish     = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                cmd.sweep_run  = 1'b1;
                cmd.sweep_kind = SWEEP_INIT;
                if (status.sweep_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.clear_req)
                    begin
                        state_next = ST_CLEAR;
                    end
                    else if (status.scroll_req)
                    begin
                        state_next = ST_SCROLL;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCROLL:
            begin
                cmd.sweep_run  = 1'b1;
                cmd.sweep_kind = SWEEP_SCROLL;
                if (status.sweep_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_CLEAR:
            begin
                cmd.sweep_run  = 1'b1;
                cmd.sweep_kind = SWEEP_CLEAR;
                if (status.sweep_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A scroll only ever starts from an accepted character that ran off the last row.
    a_scroll_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCROLL) && ($past(state_reg) != ST_SCROLL)
        |-> $past(cmd.accept && status.scroll_req))
        else $error("scroll sweep entered without a scrolling item");

    // While items are taken no sweep may be touching the screen store.
    a_no_sweep_when_open: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !cmd.sweep_run)
        else $error("sweep running while the input is open");

endmodule

/* rtl/tccw_datapath.sv */
// Datapath: cursor, screen store, sweep counter, default colors and result register.
`timescale 1ns / 1ps

module tccw_datapath
    import tccw_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEFAULT,
    parameter int ROWS    = ROWS_DEFAULT
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write_en,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [COLOR_W-1:0]      cfg_data,
    input  logic [MODE_W-1:0]       mode,
    input  logic [CHAR_W-1:0]       char_code,
    input  logic [COLOR_W-1:0]      back_color,
    input  logic [COLOR_W-1:0]      fore_color,
    input  logic [COLUMN_W-1:0]     column,
    input  logic [LINE_W-1:0]       line_number,
    input  logic                    out_stall,
    input  tccw_cmd_t               cmd,
    output tccw_status_t            status,
    output logic                    out_valid,
    output logic [CURSOR_LOC_W-1:0] cursor_location,
    output logic [CELL_W-1:0]       cell_word
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int MOVE  = (ROWS - 1) * COLUMNS;
    localparam int CW    = $clog2(COLUMNS);
    localparam int CW1   = CW + 1;
    localparam int RW    = $clog2(ROWS);
    localparam int RW1   = RW + 1;
    localparam int AW    = $clog2(CELLS);
    localparam int SW    = $clog2(CELLS + 1);
    localparam int LOC_W = (AW > CURSOR_LOC_W) ? AW : CURSOR_LOC_W;

    logic [CW-1:0]      cursor_col_reg;
    logic [CW-1:0]      cursor_col_next;
    logic [RW-1:0]      cursor_row_reg;
    logic [RW-1:0]      cursor_row_next;
    logic [SW-1:0]      sweep_cnt_reg;
    logic [COLOR_W-1:0] dflt_back_reg;
    logic [COLOR_W-1:0] dflt_fore_reg;
    logic               out_valid_reg;
    logic [CURSOR_LOC_W-1:0] cursor_location_reg;
    logic [CELL_W-1:0]  cell_word_reg;
    logic               word_sel_reg;
    logic [CELL_W-1:0]  rd_data_reg;

    logic [CELL_W-1:0]  mem [CELLS];

    logic [CW1-1:0]     col_tmp;
    logic [RW1-1:0]     row_tmp;
    logic               char_we;
    logic [CW-1:0]      char_col;
    logic [CELL_W-1:0]  char_data;
    logic               char_scroll;
    logic [CW-1:0]      char_col_next;
    logic [RW-1:0]      char_row_next;
    logic [CW-1:0]      sat_col;
    logic [RW-1:0]      sat_row;
    logic [CW-1:0]      addr_col;
    logic [RW-1:0]      addr_row;
    logic [AW-1:0]      pos_addr;
    logic [SW-1:0]      sweep_wr_idx;
    logic [SW-1:0]      sweep_rd_idx;
    logic               sweep_done;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [CELL_W-1:0]  wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [LOC_W-1:0]   loc_full;

    // Terminal interpretation of one byte at the current cursor.
    always_comb
    begin
        col_tmp   = {1'b0, cursor_col_reg};
        row_tmp   = {1'b0, cursor_row_reg};
        char_we   = 1'b0;
        char_col  = cursor_col_reg;
        char_data = make_cell(back_color, fore_color, char_code);
        case (char_code)
            CH_BACKSPACE:
            begin
                if (cursor_col_reg != '0)
                begin
                    col_tmp   = col_tmp - 1'b1;
                    char_we   = 1'b1;
                    char_col  = cursor_col_reg - 1'b1;
                    char_data = make_cell(dflt_back_reg, dflt_fore_reg, CH_SPACE);
                end
            end
            CH_TAB:
            begin
                col_tmp = (col_tmp + CW1'(8)) & ~CW1'(7);
            end
            CH_CR:
            begin
                col_tmp = '0;
            end
            CH_LF:
            begin
                col_tmp = '0;
                row_tmp = row_tmp + 1'b1;
            end
            default:
            begin
                if (char_code inside {[CH_SPACE:CH_PRINT_LAST]})
                begin
                    char_we = 1'b1;
                    col_tmp = col_tmp + 1'b1;
                end
            end
        endcase
        if (col_tmp >= CW1'(COLUMNS))
        begin
            col_tmp = '0;
            row_tmp = row_tmp + 1'b1;
        end
        char_scroll   = (row_tmp >= RW1'(ROWS));
        char_row_next = char_scroll ? RW'(ROWS - 1) : row_tmp[RW-1:0];
        char_col_next = col_tmp[CW-1:0];
    end

    always_comb
    begin
        sat_col = ({1'b0, column} > 8'(COLUMNS - 1)) ? CW'(COLUMNS - 1) : CW'(column);
        sat_row = ({1'b0, line_number} > 6'(ROWS - 1)) ? RW'(ROWS - 1) : RW'(line_number);
    end

    always_comb
    begin
        if (mode == MODE_READ_CELL)
        begin
            addr_col = sat_col;
            addr_row = sat_row;
        end
        else
        begin
            addr_col = char_col;
            addr_row = cursor_row_reg;
        end
        pos_addr = AW'(addr_row) * AW'(COLUMNS) + AW'(addr_col);
    end

    always_comb
    begin
        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;
        case (mode)
            MODE_WRITE_CHAR:
            begin
                cursor_col_next = char_col_next;
                cursor_row_next = char_row_next;
            end
            MODE_SET_CURSOR:
            begin
                cursor_col_next = sat_col;
                cursor_row_next = sat_row;
            end
            MODE_CLEAR:
            begin
                cursor_col_next = '0;
                cursor_row_next = '0;
            end
            default:
            begin
                cursor_col_next = cursor_col_reg;
                cursor_row_next = cursor_row_reg;
            end
        endcase
    end

    // Sweeps write cell (count - 1); a scroll reads cell (count + COLUMNS), one row ahead of the count.
    always_comb
    begin
        sweep_done   = (sweep_cnt_reg == SW'(CELLS));
        sweep_wr_idx = sweep_cnt_reg - 1'b1;
        sweep_rd_idx = sweep_cnt_reg + SW'(COLUMNS);
        wr_en   = 1'b0;
        wr_addr = pos_addr;
        wr_data = char_data;
        rd_en   = 1'b0;
        rd_addr = pos_addr;
        if (cmd.sweep_run)
        begin
            wr_en   = (sweep_cnt_reg != '0);
            wr_addr = sweep_wr_idx[AW-1:0];
            rd_addr = sweep_rd_idx[AW-1:0];
            case (cmd.sweep_kind)
                SWEEP_CLEAR:
                begin
                    wr_data = make_cell(dflt_back_reg, dflt_fore_reg, CH_SPACE);
                end
                SWEEP_SCROLL:
                begin
                    rd_en   = (sweep_cnt_reg < SW'(MOVE));
                    wr_data = (sweep_wr_idx < SW'(MOVE)) ? rd_data_reg : BLANK_CELL;
                end
                default:
                begin
                    wr_data = BLANK_CELL;
                end
            endcase
        end
        else if (cmd.accept)
        begin
            wr_en = (mode == MODE_WRITE_CHAR) && char_we;
            rd_en = (mode == MODE_READ_CELL);
        end
    end

    assign loc_full = LOC_W'(cursor_row_reg) * LOC_W'(COLUMNS) + LOC_W'(cursor_col_reg);

    assign status.clear_req  = (mode == MODE_CLEAR);
    assign status.scroll_req = (mode == MODE_WRITE_CHAR) && char_scroll;
    assign status.sweep_done = sweep_done;
    assign status.out_free   = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
            sweep_cnt_reg  <= '0;
            dflt_back_reg  <= DEFAULT_BACK_RESET;
            dflt_fore_reg  <= DEFAULT_FORE_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_DEFAULT_BACK: dflt_back_reg <= cfg_data;
                    CFG_DEFAULT_FORE: dflt_fore_reg <= cfg_data;
                    default:          dflt_back_reg <= dflt_back_reg;
                endcase
            end
            if (cmd.accept)
            begin
                cursor_col_reg <= cursor_col_next;
                cursor_row_reg <= cursor_row_next;
                sweep_cnt_reg  <= '0;
            end
            else if (cmd.sweep_run && !sweep_done)
            begin
                sweep_cnt_reg <= sweep_cnt_reg + 1'b1;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            word_sel_reg <= (mode == MODE_READ_CELL);
        end
        if (cmd.finish)
        begin
            cursor_location_reg <= loc_full[CURSOR_LOC_W-1:0];
            cell_word_reg       <= word_sel_reg ? rd_data_reg : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign out_valid       = out_valid_reg;
    assign cursor_location = cursor_location_reg;
    assign cell_word       = cell_word_reg;

    // The cursor never rests outside the screen between items.
    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, cursor_col_reg} < CW1'(COLUMNS)) && ({1'b0, cursor_row_reg} < RW1'(ROWS)))
        else $error("cursor outside the screen");

    // During a scroll the read must stay strictly ahead of the write.
    a_scroll_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sweep_run && rd_en && wr_en |-> (rd_addr > wr_addr))
        else $error("scroll read fell behind the write pointer");

endmodule

/* rtl/text_console_char_writer.sv */
// Top level of the text console character writer: controller and datapath.
`timescale 1ns / 1ps
//
//  Port group   Direction  Handshake            Payload
//  input item   in         in_valid / in_stall  mode, char_code, back_color, fore_color,
//                                               column, line_number
//  result item  out        out_valid/out_stall  cursor_location, cell_word
//  config       in         cfg_write_en         cfg_index, cfg_data
//
//  Characters, cursor moves and cell reads do any store access in the accept cycle;
//  the finish step then loads the result register once the output is free.
//  A scroll or a clear sweeps every cell of the store (one read port, one write port).
//  After reset a clearing pass fills every cell with a blank; in_stall stays high
//  meanwhile, config writes are taken as ever.
//  A result waiting under out_stall holds the next item in the finish step.

module text_console_char_writer
    import tccw_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEFAULT,
    parameter int ROWS    = ROWS_DEFAULT
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write_en,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [COLOR_W-1:0]      cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [MODE_W-1:0]       mode,
    input  logic [CHAR_W-1:0]       char_code,
    input  logic [COLOR_W-1:0]      back_color,
    input  logic [COLOR_W-1:0]      fore_color,
    input  logic [COLUMN_W-1:0]     column,
    input  logic [LINE_W-1:0]       line_number,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [CURSOR_LOC_W-1:0] cursor_location,
    output logic [CELL_W-1:0]       cell_word
);

    tccw_cmd_t    cmd;
    tccw_status_t status;

    tccw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    tccw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mode            (mode),
        .char_code       (char_code),
        .back_color      (back_color),
        .fore_color      (fore_color),
        .column          (column),
        .line_number     (line_number),
        .out_stall       (out_stall),
        .cmd             (cmd),
        .status          (status),
        .out_valid       (out_valid),
        .cursor_location (cursor_location),
        .cell_word       (cell_word)
    );

endmodule
